// File: design/mpt_pkg.sv
// Shared types, constants and helper functions of the marker pose tracker.
// No dependencies; every other design file uses this package by scoped names.
`default_nettype none

package mpt_pkg;

  // Pixel and fixed-point format
  localparam int PIXEL_BITS    = 12;
  localparam int FRACTION_BITS = 4;
  localparam int PT_FRAC       = FRACTION_BITS + 2;
  localparam int CORNER_W      = PIXEL_BITS + FRACTION_BITS;
  localparam int SUM_W         = CORNER_W + 2;
  localparam int ID_W          = 6;
  localparam int WORLD_W       = 16;
  localparam int ANG_W         = 16;
  localparam int REG_W         = 32;
  localparam int NUM_REGS      = 8;
  localparam int IDX_W         = $clog2(NUM_REGS);

  // Homography datapath
  localparam int PROD_W    = REG_W + SUM_W + 1;
  localparam int ACC_W     = PROD_W + 3;
  localparam int MAG_W     = ACC_W - 1;
  localparam int QUOT_W    = 32;
  localparam int DIV_SHIFT = 14 + FRACTION_BITS;
  localparam int PRE_SHIFT = QUOT_W - DIV_SHIFT - 1;
  localparam int WORLD_LIMIT = 1 << 30;
  localparam int DEN_ONE   = 30 + PT_FRAC;
  localparam int H_UNITY   = 65536;

  // CORDIC
  localparam int CORDIC_W     = 36;
  localparam int Z_W          = 24;
  localparam int CORDIC_STEPS = 16;
  localparam logic [Z_W-1:0] ANG_PI     = 24'h800000;
  localparam logic [Z_W-1:0] ANG_OFFSET = 24'hC00000;
  localparam logic [Z_W-1:0] ANG_ROUND  = 24'd128;

  // Parallax: c + round(d * 429 / 500); d clamped where the result saturates anyway
  localparam int CENTRE_X    = 420 << FRACTION_BITS;
  localparam int CENTRE_Y    = 220 << FRACTION_BITS;
  localparam int PAR_NUM     = 429;
  localparam int PAR_HALF    = 250;
  localparam int PAR_CLAMP   = 1 << 17;
  localparam int RECIP_125   = 17179870;
  localparam int RECIP_125_SH = 31;

  // Heading smoothing: prev + round(3 * d / 10)
  localparam int SM_NUM      = 3;
  localparam int SM_HALF     = 5;
  localparam int RECIP_10    = 104858;
  localparam int RECIP_10_SH = 20;

  // Follow radius squared, in pixels
  localparam int FOLLOW_R2 = 1600;

  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [IDX_W-1:0] {
    REG_H_XX, REG_H_XY, REG_H_XT, REG_H_YX,
    REG_H_YY, REG_H_YT, REG_H_PX, REG_H_PY
  } reg_idx_t;

  typedef enum logic [1:0] {
    ROLE_LEADER   = 2'd0,
    ROLE_FOLLOWER = 2'd1,
    ROLE_TARGET   = 2'd2
  } role_t;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_FOLLOW = 2'd1,
    MODE_CATCH  = 2'd2
  } mode_t;

  localparam logic [ID_W-1:0] ID_LEADER   = 6'd0;
  localparam logic [ID_W-1:0] ID_FOLLOWER = 6'd1;
  localparam logic [ID_W-1:0] ID_TARGET   = 6'd2;

  typedef enum logic [3:0] {
    B_IDLE, B_LOAD, B_MUL, B_DIV_START, B_DIV_WAIT, B_CORD_INIT, B_CORDIC,
    B_PAR_A, B_PAR_B, B_PAR_C, B_SMOOTH_A, B_SMOOTH_B, B_OUT
  } back_state_t;

  // One classified marker on its way to the back end
  typedef struct packed {
    role_t               role;
    logic [SUM_W-1:0]    sx;
    logic [SUM_W-1:0]    sy;
    logic [CORNER_W-1:0] c0x;
    logic [CORNER_W-1:0] c0y;
    logic [CORNER_W-1:0] c1x;
    logic [CORNER_W-1:0] c1y;
  } item_t;

  // atan(2^-i) with 2^23 = pi
  function automatic logic [Z_W-1:0] atan_tab(input logic [3:0] i);
    logic [Z_W-1:0] v;
    case (i)
      4'd0:  v = 24'd2097152;
      4'd1:  v = 24'd1238021;
      4'd2:  v = 24'd654136;
      4'd3:  v = 24'd332050;
      4'd4:  v = 24'd166669;
      4'd5:  v = 24'd83416;
      4'd6:  v = 24'd41718;
      4'd7:  v = 24'd20860;
      4'd8:  v = 24'd10430;
      4'd9:  v = 24'd5215;
      4'd10: v = 24'd2608;
      4'd11: v = 24'd1304;
      4'd12: v = 24'd652;
      4'd13: v = 24'd326;
      4'd14: v = 24'd163;
      4'd15: v = 24'd81;
      default: v = 24'd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [WORLD_W-1:0] sat_world(input logic signed [31:0] v);
    logic signed [WORLD_W-1:0] r;
    if (v > 32'sd32767) r = 16'sh7FFF;
    else if (v < -32'sd32768) r = 16'sh8000;
    else r = v[WORLD_W-1:0];
    return r;
  endfunction

  function automatic logic signed [18:0] par_clamp(input logic signed [32:0] d);
    logic signed [18:0] r;
    if (d > 33'(PAR_CLAMP)) r = 19'(PAR_CLAMP);
    else if (d < -33'(PAR_CLAMP)) r = -19'(PAR_CLAMP);
    else r = d[18:0];
    return r;
  endfunction

endpackage

`default_nettype wire

// File: design/mpt_front.sv
// Front end: takes input beats, drops unknown ids and forms the corner sums.
// Depends on mpt_pkg.
`default_nettype none

module mpt_front (
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // corner0_x, corner0_y, corner1_x, corner1_y, corner2_x, corner2_y, corner3_x, corner3_y
  input  wire logic [127:0]          s_tdata,
  // marker_id
  input  wire logic [5:0]            s_tuser,
  output logic                       q_valid,
  input  wire logic                  q_ready,
  output mpt_pkg::item_t             q_item
);

  localparam int CW = mpt_pkg::CORNER_W;
  localparam int SW = mpt_pkg::SUM_W;

  logic keep;

  // Only leader, follower and target ids go on to the back end
  always_comb begin
    keep = s_tuser inside {mpt_pkg::ID_LEADER, mpt_pkg::ID_FOLLOWER, mpt_pkg::ID_TARGET};
  end

  assign s_tready = q_ready;
  assign q_valid  = s_tvalid && keep;

  // Corner sums: centroid with two extra fraction bits
  always_comb begin
    q_item.role = mpt_pkg::role_t'(s_tuser[1:0]);
    q_item.sx   = SW'(s_tdata[CW-1:0]) + SW'(s_tdata[3*CW-1:2*CW])
                + SW'(s_tdata[5*CW-1:4*CW]) + SW'(s_tdata[7*CW-1:6*CW]);
    q_item.sy   = SW'(s_tdata[2*CW-1:CW]) + SW'(s_tdata[4*CW-1:3*CW])
                + SW'(s_tdata[6*CW-1:5*CW]) + SW'(s_tdata[8*CW-1:7*CW]);
    q_item.c0x  = s_tdata[CW-1:0];
    q_item.c0y  = s_tdata[2*CW-1:CW];
    q_item.c1x  = s_tdata[3*CW-1:2*CW];
    q_item.c1y  = s_tdata[4*CW-1:3*CW];
  end

endmodule

`default_nettype wire

// File: design/mpt_fifo.sv
// Short queue of classified markers between front and back end.
// Depends on mpt_pkg for the entry type.
`default_nettype none

module mpt_fifo #(
  parameter int DEPTH = mpt_pkg::QUEUE_DEPTH
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire mpt_pkg::item_t in_item,
  output logic                out_valid,
  input  wire logic           out_ready,
  output mpt_pkg::item_t      out_item
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  mpt_pkg::item_t   entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign in_ready  = (count != CNT_W'(DEPTH));
  assign out_valid = (count != '0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_item  = entries[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= in_item;
  end

endmodule

`default_nettype wire

// File: design/mpt_div.sv
// Bit-serial projective divider: round(num * 2^DIV_SHIFT / den), magnitude
// saturated at WORLD_LIMIT. Depends on mpt_pkg.
`default_nettype none

module mpt_div (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  input  wire logic signed [mpt_pkg::ACC_W-1:0] num,
  input  wire logic signed [mpt_pkg::ACC_W-1:0] den,
  output logic                                  busy,
  output logic signed [mpt_pkg::QUOT_W-1:0]     quot
);

  localparam int MW = mpt_pkg::MAG_W;
  localparam int QW = mpt_pkg::QUOT_W;
  localparam int PS = mpt_pkg::PRE_SHIFT;
  localparam logic signed [QW-1:0] LIM = QW'(mpt_pkg::WORLD_LIMIT);

  logic [MW-1:0]          nmag;
  logic [MW-1:0]          dmag;
  logic                   ovf;
  logic                   neg_now;
  logic [MW-1:0]          rem;
  logic [MW-1:0]          dvs;
  logic [QW-1:0]          low;
  logic [QW-1:0]          qacc;
  logic [$clog2(QW+1)-1:0] cnt;
  logic                   neg;
  logic [MW:0]            rem2;
  logic                   qbit;
  logic [QW:0]            rnd_sum;
  logic [QW-1:0]          rnd;
  logic [QW-1:0]          rmag;

  // Operand magnitudes and the early outcomes
  always_comb begin
    nmag    = num[mpt_pkg::ACC_W-1] ? MW'(-num) : num[MW-1:0];
    dmag    = den[mpt_pkg::ACC_W-1] ? MW'(-den) : den[MW-1:0];
    neg_now = num[mpt_pkg::ACC_W-1] ^ den[mpt_pkg::ACC_W-1];
    ovf     = {{PS{1'b0}}, nmag} >= {dmag, {PS{1'b0}}};
  end

  // One restoring step, and the final rounding
  always_comb begin
    rem2    = {rem, low[QW-1]};
    qbit    = rem2 >= {1'b0, dvs};
    rnd_sum = {1'b0, qacc} + 1'b1;
    rnd     = rnd_sum[QW:1];
    rmag    = (rnd > QW'(mpt_pkg::WORLD_LIMIT)) ? QW'(mpt_pkg::WORLD_LIMIT) : rnd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      neg <= neg_now;
      dvs <= dmag;
      if (nmag == '0) begin
        quot <= '0;
      end else if (dmag == '0 || ovf) begin
        quot <= neg_now ? -LIM : LIM;
      end else begin
        busy <= 1'b1;
        rem  <= nmag >> PS;
        low  <= {nmag[PS-1:0], {(QW-PS){1'b0}}};
        qacc <= '0;
        cnt  <= '0;
      end
    end else if (busy) begin
      if (cnt == ($clog2(QW+1))'(QW)) begin
        busy <= 1'b0;
        quot <= neg ? -$signed(rmag) : $signed(rmag);
      end else begin
        rem  <= qbit ? MW'(rem2 - {1'b0, dvs}) : rem2[MW-1:0];
        qacc <= {qacc[QW-2:0], qbit};
        low  <= {low[QW-2:0], 1'b0};
        cnt  <= cnt + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: design/mpt_back.sv
// Back end: homography, CORDIC heading, parallax, smoothing, follower mode,
// configuration registers and the output register. Depends on mpt_pkg, mpt_div.
`default_nettype none

module mpt_back (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_wen,
  input  wire logic [mpt_pkg::IDX_W-1:0]   cfg_idx,
  input  wire logic [mpt_pkg::REG_W-1:0]   cfg_wdata,
  input  wire logic                        q_valid,
  output logic                             q_ready,
  input  wire mpt_pkg::item_t              q_item,
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  output logic [55:0]                      m_tdata,
  output logic [1:0]                       m_tuser
);

  localparam int AW = mpt_pkg::ACC_W;
  localparam int SW = mpt_pkg::SUM_W;
  localparam int CW = mpt_pkg::CORDIC_W;
  localparam int ZW = mpt_pkg::Z_W;
  localparam int PW = mpt_pkg::PIXEL_BITS;

  mpt_pkg::back_state_t state, state_next;

  // Configuration registers
  logic signed [mpt_pkg::REG_W-1:0] hreg [mpt_pkg::NUM_REGS];

  always_ff @(posedge clk) begin
    if (rst) begin
      hreg[mpt_pkg::REG_H_XX] <= mpt_pkg::REG_W'(mpt_pkg::H_UNITY);
      hreg[mpt_pkg::REG_H_XY] <= '0;
      hreg[mpt_pkg::REG_H_XT] <= '0;
      hreg[mpt_pkg::REG_H_YX] <= '0;
      hreg[mpt_pkg::REG_H_YY] <= mpt_pkg::REG_W'(mpt_pkg::H_UNITY);
      hreg[mpt_pkg::REG_H_YT] <= '0;
      hreg[mpt_pkg::REG_H_PX] <= '0;
      hreg[mpt_pkg::REG_H_PY] <= '0;
    end else if (cfg_wen) begin
      hreg[cfg_idx] <= cfg_wdata;
    end
  end

  mpt_pkg::item_t item;
  logic [2:0]                     mk;
  logic [1:0]                     pidx;
  logic signed [mpt_pkg::PROD_W-1:0] prod;
  logic signed [AW-1:0]           acc_den, acc_nx, acc_ny;
  logic signed [31:0]             wx, wy, ax, ay, bx, by;
  logic signed [CW-1:0]           cx, cy;
  logic [ZW-1:0]                  cz;
  logic [3:0]                     ci;
  logic signed [27:0]             pa_x, pa_y;
  logic [48:0]                    pp_x, pp_y;
  logic                           pneg_x, pneg_y;
  logic [33:0]                    sm_prod;
  logic                           sm_neg;
  logic [25:0]                    pix_dist2;
  logic [15:0]                    head_res;

  // Tracking state
  logic [15:0]       leader_heading, follower_heading;
  logic              leader_heading_seen, follower_heading_seen;
  logic [PW-1:0]     leader_pixel_x, leader_pixel_y;
  logic              leader_pixel_seen;
  mpt_pkg::mode_t    mode_now;

  // Output register
  logic                           out_valid;
  mpt_pkg::role_t                 out_role;
  logic signed [15:0]             out_wx, out_wy;
  logic [15:0]                    out_head;
  mpt_pkg::mode_t                 out_mode;

  logic                           div_start;
  logic                           busy_x, busy_y;
  logic signed [31:0]             quot_x, quot_y;
  logic                           out_load;

  // Point selection and multiplier operands
  logic [SW-1:0]            pt_x, pt_y;
  logic signed [31:0]       mul_a;
  logic signed [SW:0]       mul_b;

  always_comb begin
    case (pidx)
      2'd1:    begin pt_x = {item.c0x, 2'b00}; pt_y = {item.c0y, 2'b00}; end
      2'd2:    begin pt_x = {item.c1x, 2'b00}; pt_y = {item.c1y, 2'b00}; end
      default: begin pt_x = item.sx; pt_y = item.sy; end
    endcase
    case (mk)
      3'd0:    begin mul_a = hreg[mpt_pkg::REG_H_PX]; mul_b = $signed({1'b0, pt_x}); end
      3'd1:    begin mul_a = hreg[mpt_pkg::REG_H_PY]; mul_b = $signed({1'b0, pt_y}); end
      3'd2:    begin mul_a = hreg[mpt_pkg::REG_H_XX]; mul_b = $signed({1'b0, pt_x}); end
      3'd3:    begin mul_a = hreg[mpt_pkg::REG_H_XY]; mul_b = $signed({1'b0, pt_y}); end
      3'd4:    begin mul_a = hreg[mpt_pkg::REG_H_YX]; mul_b = $signed({1'b0, pt_x}); end
      default: begin mul_a = hreg[mpt_pkg::REG_H_YY]; mul_b = $signed({1'b0, pt_y}); end
    endcase
  end

  // Two dividers share the denominator
  mpt_div u_div_x (
    .clk(clk), .rst(rst), .start(div_start), .num(acc_nx), .den(acc_den),
    .busy(busy_x), .quot(quot_x)
  );
  mpt_div u_div_y (
    .clk(clk), .rst(rst), .start(div_start), .num(acc_ny), .den(acc_den),
    .busy(busy_y), .quot(quot_y)
  );

  // CORDIC setup and step terms
  logic signed [32:0]   vdx, vdy;
  logic signed [CW-1:0] xs, ys;

  always_comb begin
    vdx = 33'(bx) - 33'(ax);
    vdy = 33'(by) - 33'(ay);
    xs  = cx >>> ci;
    ys  = cy >>> ci;
  end

  // Parallax and smoothing terms
  logic signed [32:0] par_dx, par_dy;
  logic [27:0]        pmag_x, pmag_y;
  logic [27:0]        psum_x, psum_y;
  logic [17:0]        pq_x, pq_y;
  logic [ZW-1:0]      zr;
  logic [15:0]        h_new;
  logic [15:0]        prev_head;
  logic               prev_seen;
  logic [15:0]        dd;
  logic signed [17:0] t3;
  logic [16:0]        sm_mag;
  logic [13:0]        sm_q;
  logic [15:0]        hs;
  logic [PW-1:0]      pix_x, pix_y;
  logic signed [PW:0] fdx, fdy;
  logic signed [25:0] sq_x, sq_y;

  always_comb begin
    par_dx = 33'(wx) - 33'(mpt_pkg::CENTRE_X);
    par_dy = 33'(wy) - 33'(mpt_pkg::CENTRE_Y);
    pmag_x = pa_x[27] ? 28'(-pa_x) : 28'(pa_x);
    pmag_y = pa_y[27] ? 28'(-pa_y) : 28'(pa_y);
    psum_x = pmag_x + 28'(mpt_pkg::PAR_HALF);
    psum_y = pmag_y + 28'(mpt_pkg::PAR_HALF);
    pq_x   = pp_x[48:mpt_pkg::RECIP_125_SH];
    pq_y   = pp_y[48:mpt_pkg::RECIP_125_SH];

    zr        = cz + mpt_pkg::ANG_OFFSET + mpt_pkg::ANG_ROUND;
    h_new     = zr[ZW-1:ZW-16];
    prev_head = (item.role == mpt_pkg::ROLE_LEADER) ? leader_heading : follower_heading;
    prev_seen = (item.role == mpt_pkg::ROLE_LEADER) ? leader_heading_seen
                                                    : follower_heading_seen;
    dd     = h_new - prev_head;
    t3     = 18'($signed(dd)) * 18'(mpt_pkg::SM_NUM);
    sm_mag = (t3[17] ? 17'(-t3) : t3[16:0]) + 17'(mpt_pkg::SM_HALF);
    sm_q   = sm_prod[33:mpt_pkg::RECIP_10_SH];
    hs     = prev_seen ? (sm_neg ? prev_head - 16'(sm_q) : prev_head + 16'(sm_q)) : h_new;

    pix_x = item.sx[SW-1:mpt_pkg::PT_FRAC];
    pix_y = item.sy[SW-1:mpt_pkg::PT_FRAC];
    fdx   = $signed({1'b0, pix_x}) - $signed({1'b0, leader_pixel_x});
    fdy   = $signed({1'b0, pix_y}) - $signed({1'b0, leader_pixel_y});
    sq_x  = fdx * fdx;
    sq_y  = fdy * fdy;
  end

  assign out_load = (state == mpt_pkg::B_OUT) && (!out_valid || m_tready);

  // State register
  always_ff @(posedge clk) begin
    if (rst) state <= mpt_pkg::B_IDLE;
    else     state <= state_next;
  end

  // Sequencer: next state and strobes
  always_comb begin
    state_next = state;
    q_ready    = 1'b0;
    div_start  = 1'b0;
    case (state)
      mpt_pkg::B_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) state_next = mpt_pkg::B_LOAD;
      end
      mpt_pkg::B_LOAD: state_next = mpt_pkg::B_MUL;
      mpt_pkg::B_MUL: begin
        if (mk == 3'd6) state_next = mpt_pkg::B_DIV_START;
      end
      mpt_pkg::B_DIV_START: begin
        div_start  = 1'b1;
        state_next = mpt_pkg::B_DIV_WAIT;
      end
      mpt_pkg::B_DIV_WAIT: begin
        if (!busy_x && !busy_y) begin
          if (pidx == 2'd0 && item.role == mpt_pkg::ROLE_TARGET) state_next = mpt_pkg::B_OUT;
          else if (pidx == 2'd2) state_next = mpt_pkg::B_CORD_INIT;
          else state_next = mpt_pkg::B_LOAD;
        end
      end
      mpt_pkg::B_CORD_INIT: begin
        if (vdx == '0 && vdy == '0) state_next = mpt_pkg::B_PAR_A;
        else state_next = mpt_pkg::B_CORDIC;
      end
      mpt_pkg::B_CORDIC: begin
        if (ci == 4'(mpt_pkg::CORDIC_STEPS - 1)) state_next = mpt_pkg::B_PAR_A;
      end
      mpt_pkg::B_PAR_A:    state_next = mpt_pkg::B_PAR_B;
      mpt_pkg::B_PAR_B:    state_next = mpt_pkg::B_PAR_C;
      mpt_pkg::B_PAR_C:    state_next = mpt_pkg::B_SMOOTH_A;
      mpt_pkg::B_SMOOTH_A: state_next = mpt_pkg::B_SMOOTH_B;
      mpt_pkg::B_SMOOTH_B: state_next = mpt_pkg::B_OUT;
      mpt_pkg::B_OUT: begin
        if (out_load) state_next = mpt_pkg::B_IDLE;
      end
      default: state_next = mpt_pkg::B_IDLE;
    endcase
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state)
      mpt_pkg::B_IDLE: begin
        if (q_valid) item <= q_item;
        pidx <= 2'd0;
      end
      mpt_pkg::B_LOAD: begin
        acc_den <= AW'(1) <<< mpt_pkg::DEN_ONE;
        acc_nx  <= AW'(hreg[mpt_pkg::REG_H_XT]) <<< mpt_pkg::PT_FRAC;
        acc_ny  <= AW'(hreg[mpt_pkg::REG_H_YT]) <<< mpt_pkg::PT_FRAC;
        mk      <= 3'd0;
      end
      mpt_pkg::B_MUL: begin
        prod <= mul_a * mul_b;
        case (mk)
          3'd1, 3'd2: acc_den <= acc_den + AW'(prod);
          3'd3, 3'd4: acc_nx  <= acc_nx + AW'(prod);
          3'd5, 3'd6: acc_ny  <= acc_ny + AW'(prod);
          default: ;
        endcase
        mk <= mk + 1'b1;
      end
      mpt_pkg::B_DIV_WAIT: begin
        if (!busy_x && !busy_y) begin
          case (pidx)
            2'd0:    begin wx <= quot_x; wy <= quot_y; end
            2'd1:    begin ax <= quot_x; ay <= quot_y; end
            default: begin bx <= quot_x; by <= quot_y; end
          endcase
          pidx <= pidx + 1'b1;
        end
      end
      mpt_pkg::B_CORD_INIT: begin
        ci <= 4'd0;
        if (vdx == '0 && vdy == '0) begin
          cz <= '0;
        end else if (vdx[32]) begin
          cx <= -CW'(vdx);
          cy <= -CW'(vdy);
          cz <= mpt_pkg::ANG_PI;
        end else begin
          cx <= CW'(vdx);
          cy <= CW'(vdy);
          cz <= '0;
        end
      end
      mpt_pkg::B_CORDIC: begin
        if (cy > 0) begin
          cx <= cx + ys;
          cy <= cy - xs;
          cz <= cz + mpt_pkg::atan_tab(ci);
        end else begin
          cx <= cx - ys;
          cy <= cy + xs;
          cz <= cz - mpt_pkg::atan_tab(ci);
        end
        ci <= ci + 1'b1;
      end
      mpt_pkg::B_PAR_A: begin
        pa_x <= mpt_pkg::par_clamp(par_dx) * 28'(mpt_pkg::PAR_NUM);
        pa_y <= mpt_pkg::par_clamp(par_dy) * 28'(mpt_pkg::PAR_NUM);
      end
      mpt_pkg::B_PAR_B: begin
        pp_x   <= 49'(psum_x[25:2]) * 49'(mpt_pkg::RECIP_125);
        pp_y   <= 49'(psum_y[25:2]) * 49'(mpt_pkg::RECIP_125);
        pneg_x <= pa_x[27];
        pneg_y <= pa_y[27];
      end
      mpt_pkg::B_PAR_C: begin
        wx <= pneg_x ? 32'(mpt_pkg::CENTRE_X) - 32'(pq_x) : 32'(mpt_pkg::CENTRE_X) + 32'(pq_x);
        wy <= pneg_y ? 32'(mpt_pkg::CENTRE_Y) - 32'(pq_y) : 32'(mpt_pkg::CENTRE_Y) + 32'(pq_y);
      end
      mpt_pkg::B_SMOOTH_A: begin
        sm_prod   <= 34'(sm_mag) * 34'(mpt_pkg::RECIP_10);
        sm_neg    <= t3[17];
        pix_dist2 <= 26'(sq_x) + 26'(sq_y);
      end
      mpt_pkg::B_SMOOTH_B: head_res <= hs;
      default: ;
    endcase
  end

  // Tracking state update
  always_ff @(posedge clk) begin
    if (rst) begin
      leader_heading        <= '0;
      leader_heading_seen   <= 1'b0;
      follower_heading      <= '0;
      follower_heading_seen <= 1'b0;
      leader_pixel_x        <= '0;
      leader_pixel_y        <= '0;
      leader_pixel_seen     <= 1'b0;
      mode_now              <= mpt_pkg::MODE_IDLE;
    end else if (state == mpt_pkg::B_SMOOTH_B) begin
      if (item.role == mpt_pkg::ROLE_LEADER) begin
        leader_heading      <= hs;
        leader_heading_seen <= 1'b1;
        leader_pixel_x      <= pix_x;
        leader_pixel_y      <= pix_y;
        leader_pixel_seen   <= 1'b1;
      end else begin
        follower_heading      <= hs;
        follower_heading_seen <= 1'b1;
        if (leader_pixel_seen) begin
          mode_now <= (pix_dist2 <= 26'(mpt_pkg::FOLLOW_R2)) ? mpt_pkg::MODE_FOLLOW
                                                              : mpt_pkg::MODE_CATCH;
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_role <= item.role;
      out_wx   <= mpt_pkg::sat_world(wx);
      out_wy   <= mpt_pkg::sat_world(wy);
      out_head <= (item.role == mpt_pkg::ROLE_TARGET) ? 16'd0 : head_res;
      out_mode <= (item.role == mpt_pkg::ROLE_FOLLOWER) ? mode_now : mpt_pkg::MODE_IDLE;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'b0, out_mode, out_head, out_wy, out_wx};
  assign m_tuser  = out_role;

  // Checks
  a_target_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_role == mpt_pkg::ROLE_TARGET) |->
      (out_head == 16'd0 && out_mode == mpt_pkg::MODE_IDLE))
    else $error("target result with heading or mode set");

  a_leader_mode: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_role == mpt_pkg::ROLE_LEADER) |-> (out_mode == mpt_pkg::MODE_IDLE))
    else $error("leader result with follow mode set");

  a_mode_needs_leader: assert property (@(posedge clk) disable iff (rst)
    (mode_now != mpt_pkg::MODE_IDLE) |-> leader_pixel_seen)
    else $error("follow mode set before any leader");

  a_out_loads: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (m_tvalid && state == mpt_pkg::B_IDLE))
    else $error("result beat not presented after load");

endmodule

`default_nettype wire

// File: design/marker_pose_tracker.sv
// Top level of the marker pose tracker: front end, queue and back end.
// Depends on mpt_pkg, mpt_front, mpt_fifo, mpt_back.
//
// Takes one detected marker per input beat (id in tuser, four corners in
// tdata) and gives at most one pose beat per marker: ids 0, 1 and 2 give a
// leader, follower or target pose, all other ids are dropped without a
// result. The user must write the homography coefficients through
// cfg_wen/cfg_idx/cfg_wdata only while no marker is in flight; the block
// itself does not enforce this. The back end handles one marker at a time:
// each mapped point goes through a load state, the products on the shared
// 32x19 multiplier and a start state, then waits on the bit-serial dividers
// (32 quotient steps, then rounding and saturation). A target maps only its
// centre point; a leader or follower maps three points, then goes through a
// setup state, a 16-step CORDIC and the parallax and smoothing states (the
// CORDIC is skipped when corners 0 and 1 map to the same point). The input
// queue holds QUEUE_DEPTH markers, and a finished pose waits in the output
// register while the next marker is worked on.
`default_nettype none

module marker_pose_tracker #(
  parameter int QUEUE_DEPTH = mpt_pkg::QUEUE_DEPTH
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_wen,
  input  wire logic [mpt_pkg::IDX_W-1:0]  cfg_idx,
  input  wire logic [mpt_pkg::REG_W-1:0]  cfg_wdata,
  input  wire logic                       s_tvalid,
  output logic                            s_tready,
  // corner0_x, corner0_y, corner1_x, corner1_y, corner2_x, corner2_y, corner3_x, corner3_y
  input  wire logic [127:0]               s_tdata,
  // marker_id
  input  wire logic [5:0]                 s_tuser,
  output logic                            m_tvalid,
  input  wire logic                       m_tready,
  // world_x, world_y, heading, follow_state, zero fill
  output logic [55:0]                     m_tdata,
  // role
  output logic [1:0]                      m_tuser
);

  logic           f_valid, f_ready;
  mpt_pkg::item_t f_item;
  logic           b_valid, b_ready;
  mpt_pkg::item_t b_item;

  mpt_front u_front (
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .q_valid(f_valid), .q_ready(f_ready), .q_item(f_item)
  );

  mpt_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk(clk), .rst(rst),
    .in_valid(f_valid), .in_ready(f_ready), .in_item(f_item),
    .out_valid(b_valid), .out_ready(b_ready), .out_item(b_item)
  );

  mpt_back u_back (
    .clk(clk), .rst(rst),
    .cfg_wen(cfg_wen), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
    .q_valid(b_valid), .q_ready(b_ready), .q_item(b_item),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

endmodule

`default_nettype wire
